@@ src/dsfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dsfe_pkg;

    // Framing symbols
    localparam logic [7:0] SYM_DLE = 8'h10;
    localparam logic [7:0] SYM_STX = 8'h02;
    localparam logic [7:0] SYM_ETX = 8'h03;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Output sequence positions for one command
    localparam logic [2:0] PH_HDR_DLE = 3'd0;
    localparam logic [2:0] PH_HDR_STX = 3'd1;
    localparam logic [2:0] PH_STUFF   = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_TR_DLE  = 3'd4;
    localparam logic [2:0] PH_TR_ETX  = 3'd5;
    localparam logic [2:0] PH_BCC     = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // One classified payload word, as handed from front to back
    typedef struct packed {
        logic       hdr;    // opens a frame: DLE STX first
        logic       stuff;  // payload equals DLE: send it twice
        logic       last;   // closes the frame: DLE ETX BCC after it
        logic [7:0] data;
        logic [7:0] bcc;    // check byte, meaningful when last is set
    } cmd_t;

    // First output position of a command
    function automatic logic [2:0] first_phase(input cmd_t c);
        logic [2:0] p;
        if (c.hdr)
            p = PH_HDR_DLE;
        else if (c.stuff)
            p = PH_STUFF;
        else
            p = PH_DATA;
        return p;
    endfunction

    // Position that follows p for command c, PH_DONE after the final one
    function automatic logic [2:0] next_phase(input logic [2:0] p, input cmd_t c);
        logic [2:0] n;
        case (p)
            PH_HDR_DLE: n = PH_HDR_STX;
            PH_HDR_STX: n = c.stuff ? PH_STUFF : PH_DATA;
            PH_STUFF:   n = PH_DATA;
            PH_DATA:    n = c.last ? PH_TR_DLE : PH_DONE;
            PH_TR_DLE:  n = PH_TR_ETX;
            PH_TR_ETX:  n = PH_BCC;
            default:    n = PH_DONE;
        endcase
        return n;
    endfunction

    // Byte sent at position p
    function automatic logic [7:0] phase_byte(input logic [2:0] p, input cmd_t c);
        logic [7:0] b;
        case (p)
            PH_HDR_DLE: b = SYM_DLE;
            PH_HDR_STX: b = SYM_STX;
            PH_STUFF:   b = SYM_DLE;
            PH_DATA:    b = c.data;
            PH_TR_DLE:  b = SYM_DLE;
            PH_TR_ETX:  b = SYM_ETX;
            default:    b = c.bcc;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ src/dsfe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsfe_front
    import dsfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            push,
    output cmd_t            push_cmd,
    input  wire logic       queue_ready
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] check_accum_reg;
    logic [7:0] check_accum_next;
    logic [7:0] acc_base;
    logic [7:0] acc_new;

    assign in_ready = queue_ready;
    assign push     = in_valid && queue_ready;

    // Classify the word; the check sum restarts when a frame opens
    assign acc_base = in_frame_reg ? check_accum_reg : 8'h00;
    assign acc_new  = acc_base ^ data_byte;

    always_comb
    begin
        push_cmd.hdr   = !in_frame_reg;
        push_cmd.stuff = (data_byte == SYM_DLE);
        push_cmd.last  = last_byte;
        push_cmd.data  = data_byte;
        push_cmd.bcc   = acc_new ^ SYM_ETX;
    end

    // Frame state advances on every accepted word
    always_comb
    begin
        in_frame_next    = in_frame_reg;
        check_accum_next = check_accum_reg;
        if (push)
        begin
            in_frame_next    = !last_byte;
            check_accum_next = last_byte ? 8'h00 : acc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            check_accum_reg <= 8'h00;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            check_accum_reg <= check_accum_next;
        end
    end

endmodule

`default_nettype wire

@@ src/dsfe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsfe_queue
    import dsfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

@@ src/dsfe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsfe_back
    import dsfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire cmd_t head_cmd,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [7:0] out_byte,
    output logic      frame_end
);

    logic       active_reg;
    logic       active_next;
    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;
    logic [2:0] cur_phase;
    logic [2:0] nxt_phase;
    logic       load;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

    // Position within the head command
    assign cur_phase = active_reg ? phase_reg : first_phase(head_cmd);
    assign nxt_phase = next_phase(cur_phase, head_cmd);
    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = load && (nxt_phase == PH_DONE);

    // Sequencer and output register control
    always_comb
    begin
        active_next    = active_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            active_next    = (nxt_phase != PH_DONE);
            phase_next     = nxt_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            phase_reg     <= PH_HDR_DLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= phase_byte(cur_phase, head_cmd);
            frame_end_reg <= (cur_phase == PH_BCC);
        end
    end

endmodule

`default_nettype wire

@@ src/dle_stx_frame_encoder_top.sv @@
// Channel  Handshake                Word
// -------  -----------------------  -----------------------------
// input    in_valid / in_ready      data_byte[7:0], last_byte
// output   out_valid / out_ready    out_byte[7:0], frame_end
//
// The output sequencer sends one byte per cycle while out_ready is high;
// an input word makes 1 to 7 output bytes, so a frame of plain bytes runs
// at one input word per cycle plus header and trailer.
// The front accepts a new word each cycle while the command queue has room.
// Reset is asynchronous, active low, and closes any open frame.
// A stalled output holds its byte; the queue absorbs input meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module dle_stx_frame_encoder_top
    import dsfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            frame_end
);

    logic push;
    cmd_t push_cmd;
    logic queue_ready;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Front: accept and classify
    dsfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .push        (push),
        .push_cmd    (push_cmd),
        .queue_ready (queue_ready)
    );

    // Command queue
    dsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: byte sequencer
    dsfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire

@@ test/dle_stx_frame_encoder_top_tb.sv @@
`timescale 1ns / 1ps

module dle_stx_frame_encoder_top_tb;

    import dsfe_pkg::*;

    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;    // settle time after the last byte
    localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int PHASE_WORDS  = 70;    // least random words per idling phase

    // One directed word; n > 0 means the framed bytes are typed in, first byte in
    // the top slot of bytes
    typedef struct {
        logic [7:0]  data;
        logic        last;
        int          n;
        logic [55:0] bytes;
    } dir_row_t;

    // One framed output byte
    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } framed_byte_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       frame_end;

    dir_row_t     dir_rows [$];
    framed_byte_t framed_q [$];
    int           cur_row        = -1;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    bit           hold_req       = 1'b0;
    int           fail_cnt       = 0;
    int           quiet_cnt      = 0;

    // Predictor state: frame open flag and running XOR
    logic         frame_open = 1'b0;
    logic [7:0]   xor_acc    = 8'h00;

    dle_stx_frame_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Framed bytes caused by one payload word; updates the predictor state
    function automatic int frame_word(input logic [7:0] d, input logic l,
                                      output logic [7:0] b [7], output logic e [7]);
        int         n;
        int         i;
        logic [7:0] bcc;
        n = 0;
        for (i = 0; i < 7; i++)
        begin
            b[i] = 8'h00;
            e[i] = 1'b0;
        end
        // header opens the frame and restarts the check byte
        if (!frame_open)
        begin
            b[n] = SYM_DLE; n++;
            b[n] = SYM_STX; n++;
            xor_acc    = 8'h00;
            frame_open = 1'b1;
        end
        // DLE in the payload goes out twice, counted once
        if (d == SYM_DLE)
        begin
            b[n] = SYM_DLE; n++;
        end
        b[n] = d; n++;
        xor_acc = xor_acc ^ d;
        // trailer; check byte is never stuffed
        if (l)
        begin
            bcc  = xor_acc ^ SYM_ETX;
            b[n] = SYM_DLE; n++;
            b[n] = SYM_ETX; n++;
            b[n] = bcc;
            e[n] = 1'b1;
            n++;
            frame_open = 1'b0;
            xor_acc    = 8'h00;
        end
        return n;
    endfunction

    // Payload byte biased toward the framing symbols
    function automatic logic [7:0] pick_byte();
        int r;
        logic [7:0] v;
        r = $urandom_range(99);
        if (r < 20)
            v = SYM_DLE;
        else if (r < 28)
            v = SYM_STX;
        else if (r < 36)
            v = SYM_ETX;
        else if (r < 42)
            v = 8'h00;
        else if (r < 48)
            v = 8'hFF;
        else
            v = 8'($urandom_range(255));
        return v;
    endfunction

    task automatic add_row(input logic [7:0] d, input logic l, input int n,
                           input logic [55:0] bytes);
        dir_row_t r;
        r.data  = d;
        r.last  = l;
        r.n     = n;
        r.bytes = bytes;
        dir_rows.push_back(r);
    endtask

    // Offer one word, maybe after an idle gap, and wait until it is taken
    task automatic offer_word(input logic [7:0] d, input logic l, input int row);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        cur_row   <= row;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Sender pause until every framed byte has come out
    task automatic drain();
        in_valid <= 1'b0;
        // let the monitor queue the bytes of the word taken at this edge
        @(posedge clk);
        while (framed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    // Accepted input word: queue its framed bytes
    always @(posedge clk)
    begin : in_mon
        logic [7:0] pb [7];
        logic       pe [7];
        int         n;
        int         k;
        dir_row_t   r;
        if (rst_n && in_valid && in_ready)
        begin
            n = frame_word(data_byte, last_byte, pb, pe);
            if (cur_row >= 0 && dir_rows[cur_row].n > 0)
            begin
                r = dir_rows[cur_row];
                for (k = 0; k < r.n; k++)
                    framed_q.push_back({r.bytes[55 - 8 * k -: 8], r.last && (k == r.n - 1)});
            end
            else
            begin
                for (k = 0; k < n; k++)
                    framed_q.push_back({pb[k], pe[k]});
            end
        end
    end

    // Accepted output byte: compare with the oldest expected one
    always @(posedge clk)
    begin : out_mon
        framed_byte_t x;
        if (rst_n && out_valid && out_ready)
        begin
            if (framed_q.size() == 0)
            begin
                $error("unexpected output byte %h frame_end %b", out_byte, frame_end);
                fail_cnt++;
            end
            else
            begin
                x = framed_q.pop_front();
                if (out_byte !== x.b)
                begin
                    $error("out_byte: expected %h, got %h", x.b, out_byte);
                    fail_cnt++;
                end
                if (frame_end !== x.e)
                begin
                    $error("frame_end: expected %b, got %b", x.e, frame_end);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= STALL_LIMIT)
            begin
                $display("[dle_stx_frame_encoder_top] ERROR");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin : main_seq
        int sent;
        int flen;
        int k;
        int ph;

        // directed table: single-word frames at the extremes, then open frames
        add_row(8'h00, 1'b1, 6, {SYM_DLE, SYM_STX, 8'h00, SYM_DLE, SYM_ETX, 8'h03, 8'h00});
        add_row(8'hFF, 1'b1, 6, {SYM_DLE, SYM_STX, 8'hFF, SYM_DLE, SYM_ETX, 8'hFC, 8'h00});
        add_row(SYM_DLE, 1'b1, 7,
                {SYM_DLE, SYM_STX, SYM_DLE, SYM_DLE, SYM_DLE, SYM_ETX, 8'h13});
        // check byte equal to DLE goes out once
        add_row(8'h13, 1'b1, 6, {SYM_DLE, SYM_STX, 8'h13, SYM_DLE, SYM_ETX, SYM_DLE, 8'h00});
        add_row(SYM_ETX, 1'b1, 6, {SYM_DLE, SYM_STX, SYM_ETX, SYM_DLE, SYM_ETX, 8'h00, 8'h00});
        add_row(SYM_STX, 1'b1, 6, {SYM_DLE, SYM_STX, SYM_STX, SYM_DLE, SYM_ETX, 8'h01, 8'h00});
        add_row(8'hAA, 1'b0, 3, {SYM_DLE, SYM_STX, 8'hAA, 32'h0});
        add_row(8'h55, 1'b0, 1, {8'h55, 48'h0});
        add_row(SYM_DLE, 1'b0, 2, {SYM_DLE, SYM_DLE, 40'h0});
        add_row(8'h00, 1'b1, 4, {8'h00, SYM_DLE, SYM_ETX, 8'hEC, 24'h0});
        // longer frame with symbols inside, stuffed last word
        add_row(SYM_DLE, 1'b0, 0, 56'h0);
        add_row(SYM_DLE, 1'b0, 0, 56'h0);
        add_row(SYM_STX, 1'b0, 0, 56'h0);
        add_row(SYM_ETX, 1'b0, 0, 56'h0);
        add_row(8'h80, 1'b0, 0, 56'h0);
        add_row(8'h01, 1'b0, 0, 56'h0);
        add_row(8'h7F, 1'b0, 0, 56'h0);
        add_row(SYM_DLE, 1'b1, 0, 56'h0);
        add_row(8'h5A, 1'b0, 0, 56'h0);
        add_row(8'h4C, 1'b1, 0, 56'h0);
        add_row(SYM_DLE, 1'b0, 0, 56'h0);
        add_row(8'hFE, 1'b1, 0, 56'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_rows.size(); k++)
            offer_word(dir_rows[k].data, dir_rows[k].last, k);
        drain();

        // random frames, one idling phase each
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // long hold-off while words keep coming, so the block backs up
            if (ph == 0)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                flen = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
                for (k = 0; k < flen; k++)
                begin
                    offer_word(pick_byte(), k == flen - 1, -1);
                    sent++;
                end
            end
            drain();
        end

        if (fail_cnt == 0 && framed_q.size() == 0)
            $display("[dle_stx_frame_encoder_top] OK");
        else
            $display("[dle_stx_frame_encoder_top] ERROR");
        $finish;
    end

endmodule

@@ dle_stx_frame_encoder_top.f @@
src/dsfe_pkg.sv
src/dsfe_front.sv
src/dsfe_queue.sv
src/dsfe_back.sv
src/dle_stx_frame_encoder_top.sv
test/dle_stx_frame_encoder_top_tb.sv
